// ----- rtl/core/wpsg_pkg.sv -----
`timescale 1ns / 1ps
package wpsg_pkg;
    localparam int CW = 16;
    localparam int DW = CW + 1;
    localparam int SW = 2 * DW + 2;
    localparam int CORDIC_STEPS = 16;
    localparam int ZW = 22;
    localparam int CXW = 34;
    localparam int MAX_WAYPOINTS = 16;
    localparam logic signed [ZW-1:0] ANGLE_PI = 22'sd524288;

    localparam logic [1:0] CFG_COUNT  = 2'd0;
    localparam logic [1:0] CFG_STEP   = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    localparam logic OP_WRITE = 1'b0;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_READ   = 9'b000000010,
        ST_SQUARE = 9'b000000100,
        ST_SQRT   = 9'b000001000,
        ST_MUL    = 9'b000010000,
        ST_DIV    = 9'b000100000,
        ST_CORDIC = 9'b001000000,
        ST_OUT    = 9'b010000000,
        ST_WAIT   = 9'b100000000
    } state_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [3:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            4'd0: v = 22'sd131072;
            4'd1: v = 22'sd77376;
            4'd2: v = 22'sd40884;
            4'd3: v = 22'sd20753;
            4'd4: v = 22'sd10417;
            4'd5: v = 22'sd5213;
            4'd6: v = 22'sd2607;
            4'd7: v = 22'sd1304;
            4'd8: v = 22'sd652;
            4'd9: v = 22'sd326;
            4'd10: v = 22'sd163;
            4'd11: v = 22'sd81;
            4'd12: v = 22'sd41;
            4'd13: v = 22'sd20;
            4'd14: v = 22'sd10;
            default: v = 22'sd5;
        endcase
        return v;
    endfunction
endpackage

// ----- rtl/core/wpsg_ram.sv -----
`timescale 1ns / 1ps
module wpsg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ----- rtl/core/waypoint_step_limited_guidance.sv -----
`timescale 1ns / 1ps
// waypoint follower with a step-limited target
// input channel s_*: opcode 0 writes one table slot and gives no result, opcode 1 is a
// pose sample and gives one result on m_*. config channel cfg_*: index 0 waypoint count,
// 1 step limit, 2 arrival radius; write only while idle.
// a table write is taken while idle without leaving it, so writes may follow every cycle.
// a pose is worked through read, squares (one bit a cycle), compare and cordic when the
// step is not limited; when it is limited the compare is followed by root (two bits a
// cycle), then per axis a product and a quotient, and then the cordic.
// one request is worked at a time; s_ready is high only while idle, so the next request
// is taken only once the result before it has been taken on m_*.
// the result is held in an output register until m_ready; no new request is
// taken while it waits. reset returns the index to 0 and the registers to
// count 5, step 256, radius 128; table contents stay undefined until written.
module waypoint_step_limited_guidance
    import wpsg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  logic [3:0]           s_entry_index,
    input  logic signed [CW-1:0] s_coord_x,
    input  logic signed [CW-1:0] s_coord_y,
    input  logic signed [CW-1:0] s_coord_z,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [14:0]          cfg_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [CW-1:0] m_target_x,
    output logic signed [CW-1:0] m_target_y,
    output logic signed [CW-1:0] m_target_z,
    output logic signed [CW-1:0] m_target_heading,
    output logic [3:0]           m_active_slot,
    output logic                 m_reached
);
    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int MW = 3 * CW;
    localparam int PW = DW + 15;
    localparam int LW = DW + 1;
    localparam int RW = LW + 4;
    localparam int SQ_STEPS = SW / 2;

    state_t state_reg, state_next;

    logic [4:0]  count_reg;
    logic [14:0] step_reg, radius_reg;
    logic [3:0]  index_reg;
    logic [3:0]  slot_reg;
    logic        reached_reg;

    logic signed [CW-1:0] px_reg, py_reg, pz_reg;
    logic signed [DW-1:0] d_reg [3];
    logic signed [CW-1:0] t_reg [3];
    logic [5:0]           cnt_reg;
    logic [1:0]           k_reg;

    // squares: multiplicand shifts left, multiplier shifts out one bit a cycle
    logic [SW-1:0]  s_reg;
    logic [SW-1:0]  mcand_reg;
    logic [DW-1:0]  mplier_reg;
    // root, two bits of the sum a cycle
    logic [RW-1:0]  rem_reg;
    logic [LW-1:0]  root_reg;
    // product and quotient
    logic [PW-1:0]  prod_reg;
    logic [LW-1:0]  qrem_reg;
    logic [CW-1:0]  quo_reg;
    // cordic
    logic signed [CXW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0]  cz_reg;
    logic [3:0]            ci_reg;

    logic [MW-1:0] ram_rd;
    logic [AW-1:0] ram_wa, ram_ra;
    logic          ram_we;

    function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    logic [4:0] cnt_eff;
    logic [3:0] slot_c;
    always_comb begin
        cnt_eff = (count_reg == 5'd0) ? 5'd1 : count_reg;
        if (cnt_eff > 5'(MAX_WAYPOINTS)) cnt_eff = 5'(MAX_WAYPOINTS);
        slot_c = ({1'b0, index_reg} < cnt_eff) ? index_reg : 4'd0;
    end

    assign ram_we = s_valid && s_ready && (s_opcode == OP_WRITE)
                    && ({1'b0, s_entry_index} < 5'(MAX_WAYPOINTS));
    assign ram_wa = AW'(s_entry_index);
    // the slot is read at the edge that takes the pose
    assign ram_ra = AW'(slot_c);

    wpsg_ram #(.WIDTH(MW), .DEPTH(MAX_WAYPOINTS)) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data ({s_coord_z, s_coord_y, s_coord_x}),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 5'd5;
            step_reg   <= 15'd256;
            radius_reg <= 15'd128;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_COUNT:  count_reg  <= cfg_data[4:0];
                CFG_STEP:   step_reg   <= cfg_data;
                CFG_RADIUS: radius_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // combinational helpers
    logic signed [CW-1:0] wx, wy, wz;
    logic signed [DW-1:0] dx_n, dy_n, dz_n;
    logic signed [DW-1:0] d_k, d_nx;
    logic signed [CW-1:0] p_k;
    logic [29:0]          step_sq, radius_sq;
    logic                 limited_c;
    logic [RW-1:0]        rem_sh, rtrial;
    logic [LW:0]          q_sh;
    logic [LW+1:0]        q_dif;
    logic                 q_bit;
    logic [CW-1:0]        quo_nx;
    logic signed [LW-1:0] t_sum;
    logic signed [CW-1:0] t_sat;

    always_comb begin
        wx   = $signed(ram_rd[CW-1:0]);
        wy   = $signed(ram_rd[2*CW-1:CW]);
        wz   = $signed(ram_rd[3*CW-1:2*CW]);
        dx_n = DW'(wx) - DW'(px_reg);
        dy_n = DW'(wy) - DW'(py_reg);
        dz_n = DW'(wz) - DW'(pz_reg);
    end

    always_comb begin
        unique case (k_reg)
            2'd0: begin
                d_k  = d_reg[0];
                d_nx = d_reg[1];
                p_k  = px_reg;
            end
            2'd1: begin
                d_k  = d_reg[1];
                d_nx = d_reg[2];
                p_k  = py_reg;
            end
            default: begin
                d_k  = d_reg[2];
                d_nx = d_reg[2];
                p_k  = pz_reg;
            end
        endcase
    end

    always_comb begin
        step_sq   = 30'(step_reg) * 30'(step_reg);
        radius_sq = 30'(radius_reg) * 30'(radius_reg);
        limited_c = s_reg > SW'(step_sq);
        rem_sh    = {rem_reg[RW-3:0], s_reg[SW-1:SW-2]};
        rtrial    = RW'({root_reg, 2'b01});
        q_sh      = {qrem_reg, prod_reg[PW-1]};
        q_dif     = {1'b0, q_sh} - {2'b00, root_reg};
        q_bit     = !q_dif[LW+1];
        quo_nx    = {quo_reg[CW-2:0], q_bit};
        // the quotient never exceeds the step limit, so 16 bits hold it
        t_sum = d_k[DW-1] ? (LW'(p_k) - LW'($signed({2'b00, quo_nx})))
                          : (LW'(p_k) + LW'($signed({2'b00, quo_nx})));
        if (t_sum > LW'(32767))
            t_sat = {1'b0, {(CW-1){1'b1}}};
        else if (t_sum < -LW'(32768))
            t_sat = {1'b1, {(CW-1){1'b0}}};
        else
            t_sat = t_sum[CW-1:0];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid && s_opcode != OP_WRITE) state_next = ST_READ;
            ST_READ:   state_next = ST_SQUARE;
            ST_SQUARE: if (k_reg == 2'd2 && cnt_reg == 6'(DW-1)) state_next = ST_WAIT;
            ST_WAIT:   state_next = limited_c ? ST_SQRT : ST_CORDIC;
            ST_SQRT:   if (cnt_reg == 6'(SQ_STEPS-1)) state_next = ST_MUL;
            ST_MUL:    if (cnt_reg == 6'd14) state_next = ST_DIV;
            ST_DIV:    if (cnt_reg == 6'(PW-1))
                           state_next = (k_reg == 2'd2) ? ST_CORDIC : ST_MUL;
            ST_CORDIC: if (ci_reg == 4'(CORDIC_STEPS-1)) state_next = ST_OUT;
            ST_OUT:    if (m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            index_reg <= 4'd0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && m_ready) begin
                if (reached_reg)
                    index_reg <= ({1'b0, slot_reg} + 5'd1 >= cnt_eff) ? 4'd0 : slot_reg + 4'd1;
                else
                    index_reg <= slot_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                px_reg   <= s_coord_x;
                py_reg   <= s_coord_y;
                pz_reg   <= s_coord_z;
                slot_reg <= slot_c;
            end
            ST_READ: begin
                d_reg[0]   <= dx_n;
                d_reg[1]   <= dy_n;
                d_reg[2]   <= dz_n;
                t_reg[0]   <= wx;
                t_reg[1]   <= wy;
                t_reg[2]   <= wz;
                s_reg      <= '0;
                mcand_reg  <= SW'(mag_of(dx_n));
                mplier_reg <= mag_of(dx_n);
                cnt_reg    <= '0;
                k_reg      <= 2'd0;
            end
            ST_SQUARE: begin
                if (mplier_reg[0])
                    s_reg <= s_reg + mcand_reg;
                if (cnt_reg == 6'(DW-1)) begin
                    mcand_reg  <= SW'(mag_of(d_nx));
                    mplier_reg <= mag_of(d_nx);
                    cnt_reg    <= '0;
                    k_reg      <= k_reg + 2'd1;
                end else begin
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg + 6'd1;
                end
            end
            ST_WAIT: begin
                reached_reg <= s_reg < SW'(radius_sq);
                rem_reg     <= '0;
                root_reg    <= '0;
                cnt_reg     <= '0;
                k_reg       <= 2'd0;
            end
            ST_SQRT: begin
                if (rem_sh >= rtrial) begin
                    rem_reg  <= rem_sh - rtrial;
                    root_reg <= {root_reg[LW-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[LW-2:0], 1'b0};
                end
                s_reg <= s_reg << 2;
                if (cnt_reg == 6'(SQ_STEPS-1)) begin
                    cnt_reg  <= '0;
                    prod_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
            end
            ST_MUL: begin
                // product |d| * step, one bit of step a cycle
                if (step_reg[4'(6'd14 - cnt_reg)])
                    prod_reg <= (prod_reg << 1) + PW'(mag_of(d_k));
                else
                    prod_reg <= prod_reg << 1;
                if (cnt_reg == 6'd14) begin
                    cnt_reg  <= '0;
                    qrem_reg <= '0;
                    quo_reg  <= '0;
                end else begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
            end
            ST_DIV: begin
                qrem_reg <= q_bit ? q_dif[LW-1:0] : q_sh[LW-1:0];
                quo_reg  <= quo_nx;
                if (cnt_reg == 6'(PW-1)) begin
                    // saturating add of the finished quotient
                    t_reg[k_reg] <= t_sat;
                    cnt_reg      <= '0;
                    k_reg        <= k_reg + 2'd1;
                    prod_reg     <= '0;
                end else begin
                    prod_reg <= prod_reg << 1;
                    cnt_reg  <= cnt_reg + 6'd1;
                end
            end
            default: ;
        endcase
    end

    // cordic start vector: turned by pi when x is negative
    logic signed [CXW-1:0] x0, y0;
    logic signed [ZW-1:0]  z0;
    always_comb begin
        x0 = CXW'(d_reg[0]) <<< (30 - CW);
        y0 = CXW'(d_reg[1]) <<< (30 - CW);
        z0 = '0;
        if (x0 < 0) begin
            z0 = (y0 >= 0) ? ANGLE_PI : -ANGLE_PI;
            x0 = -x0;
            y0 = -y0;
        end
    end

    logic signed [CXW-1:0] shx, shy;
    always_comb begin
        shx = cx_reg >>> ci_reg;
        shy = cy_reg >>> ci_reg;
    end

    // cordic: one vectoring step a cycle, loaded until it starts, held while the result waits
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CORDIC) begin
            if (cy_reg >= 0) begin
                cx_reg <= cx_reg + shy;
                cy_reg <= cy_reg - shx;
                cz_reg <= cz_reg + atan_entry(ci_reg);
            end else begin
                cx_reg <= cx_reg - shy;
                cy_reg <= cy_reg + shx;
                cz_reg <= cz_reg - atan_entry(ci_reg);
            end
            ci_reg <= ci_reg + 4'd1;
        end else if (state_reg != ST_OUT) begin
            cx_reg <= x0;
            cy_reg <= y0;
            cz_reg <= z0;
            ci_reg <= '0;
        end
    end

    logic signed [ZW-1:0] zr;
    assign zr = (cz_reg + ZW'(8)) >>> 4;

    assign m_valid          = (state_reg == ST_OUT);
    assign m_target_x       = t_reg[0];
    assign m_target_y       = t_reg[1];
    assign m_target_z       = t_reg[2];
    assign m_target_heading = (d_reg[0] == '0 && d_reg[1] == '0) ? '0 : zr[CW-1:0];
    assign m_active_slot    = slot_reg;
    assign m_reached        = reached_reg;

    a_one_hot: assert property (@(posedge aclk) disable iff (!aresetn) $onehot(state_reg))
        else $error("state not one-hot");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result waits");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_active_slot))
        else $error("result dropped");
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_active_slot} < 5'(MAX_WAYPOINTS)))
        else $error("slot out of range");
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import wpsg_pkg::*;

    typedef struct {
        logic              op;
        logic [3:0]        idx;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } request_t;

    typedef struct {
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic signed [15:0] tz;
        logic signed [15:0] hdg;
        logic [3:0]         slot;
        logic               hit;
    } target_t;

    localparam logic OP_POSE = 1'b1;
    localparam int SETTLE_CYCLES = 250;
    localparam longint CYCLE_LIMIT = 3000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_opcode = 1'b0;
    logic [3:0] s_entry_index = '0;
    logic signed [CW-1:0] s_coord_x = '0, s_coord_y = '0, s_coord_z = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [14:0] cfg_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [CW-1:0] m_target_x, m_target_y, m_target_z, m_target_heading;
    logic [3:0] m_active_slot;
    logic m_reached;

    waypoint_step_limited_guidance uut (.*);

    initial forever #6 aclk = ~aclk;

    // guidance state mirrored from the accepted requests
    longint wp_tab [16][3];
    int unsigned cur_index = 0;
    longint wp_count = 5, step_lim = 256, arr_rad = 128;

    const longint atan_lut [16] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                                    652, 326, 163, 81, 41, 20, 10, 5};

    request_t pending_req[$];
    target_t  expected_tgt[$];
    logic signed [15:0] gen_wp [16][3];
    int errors = 0;
    longint cycles = 0;
    bit no_idle = 0;
    bit s_hold = 0, s_taken = 0, m_taken = 0;
    int s_gap = 0, m_stall = 0;

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] heading_of(longint dx, longint dy);
        longint x, y, z, nx;
        if (dx == 0 && dy == 0) return '0;
        x = dx * 16384;
        y = dy * 16384;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? 524288 : -524288;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_lut[i];
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_lut[i];
            end
            x = nx;
        end
        z = (z + 8) >>> 4;
        return z[15:0];
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    task automatic guidance_step(input request_t r);
        longint p[3], d[3], t[3], cnt, len, mag;
        longint unsigned s;
        int unsigned slot;
        bit lim, hit;
        target_t e;
        p[0] = r.x;
        p[1] = r.y;
        p[2] = r.z;
        if (r.op == OP_WRITE) begin
            for (int k = 0; k < 3; k++) wp_tab[r.idx][k] = p[k];
        end else begin
            cnt = (wp_count == 0) ? 1 : (wp_count > 16 ? 16 : wp_count);
            slot = (cur_index < cnt) ? cur_index : 0;
            s = 0;
            for (int k = 0; k < 3; k++) begin
                d[k] = wp_tab[slot][k] - p[k];
                s += d[k] * d[k];
                t[k] = wp_tab[slot][k];
            end
            lim = s > step_lim * step_lim;
            hit = s < arr_rad * arr_rad;
            if (lim) begin
                len = int_sqrt(s);
                for (int k = 0; k < 3; k++) begin
                    mag = ((d[k] < 0) ? -d[k] : d[k]) * step_lim / len;
                    t[k] = p[k] + ((d[k] < 0) ? -mag : mag);
                end
            end
            e.tx = clamp16(t[0]);
            e.ty = clamp16(t[1]);
            e.tz = clamp16(t[2]);
            e.hdg = heading_of(d[0], d[1]);
            e.slot = slot[3:0];
            e.hit = hit;
            expected_tgt.push_back(e);
            cur_index = hit ? (slot + 1) % cnt : slot;
        end
    endtask

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
        if (aresetn && s_valid && s_ready) begin
            guidance_step('{s_opcode, s_entry_index, s_coord_x, s_coord_y, s_coord_z});
            s_taken = 1;
        end
        if (aresetn && m_valid && m_ready) begin
            m_taken = 1;
            if (expected_tgt.size() == 0) begin
                errors++;
                $display("%0t: unexpected result slot %0d", $time, m_active_slot);
            end else begin
                target_t e;
                e = expected_tgt.pop_front();
                if ({m_target_x, m_target_y, m_target_z, m_target_heading, m_active_slot,
                     m_reached} !== {e.tx, e.ty, e.tz, e.hdg, e.slot, e.hit}) begin
                    errors++;
                    $display("%0t: mismatch exp x=%0d y=%0d z=%0d h=%0d slot=%0d hit=%0d",
                             $time, e.tx, e.ty, e.tz, e.hdg, e.slot, e.hit);
                    $display("%0t:          got x=%0d y=%0d z=%0d h=%0d slot=%0d hit=%0d",
                             $time, m_target_x, m_target_y, m_target_z, m_target_heading,
                             m_active_slot, m_reached);
                end
            end
        end
    end

    // request driver
    always @(negedge aclk) begin
        request_t r;
        if (s_hold && s_taken) begin
            s_hold = 0;
            s_gap = no_idle ? 0 : $urandom_range(0, 11);
        end
        s_taken = 0;
        if (aresetn && !s_hold) begin
            if (s_gap > 0) begin
                s_gap--;
            end else if (pending_req.size() > 0) begin
                r = pending_req.pop_front();
                s_hold = 1;
                s_opcode <= r.op;
                s_entry_index <= r.idx;
                s_coord_x <= r.x;
                s_coord_y <= r.y;
                s_coord_z <= r.z;
            end
        end
        s_valid <= s_hold;
    end

    // result back-pressure
    always @(negedge aclk) begin
        if (m_taken) m_stall = no_idle ? 0 : $urandom_range(0, 11);
        m_taken = 0;
        if (m_stall > 0) begin
            m_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn;
        end
    end

    task automatic queue_req(logic op, logic [3:0] idx, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z);
        if (op == OP_WRITE) begin
            gen_wp[idx][0] = x;
            gen_wp[idx][1] = y;
            gen_wp[idx][2] = z;
        end
        pending_req.push_back('{op, idx, x, y, z});
    endtask

    task automatic wait_idle();
        while (pending_req.size() != 0 || s_hold) @(posedge aclk);
        while (expected_tgt.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [14:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_COUNT:  wp_count = val[4:0];
            CFG_STEP:   step_lim = val;
            CFG_RADIUS: arr_rad = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] near(logic signed [15:0] c, int span);
        return 16'(int'(c) + $urandom_range(0, 2 * span) - span);
    endfunction

    task automatic random_batch(int n);
        int mode, s, span;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(0, 99);
            s = $urandom_range(0, 15);
            if (mode < 8) begin
                queue_req(OP_WRITE, 4'(s), 16'($urandom), 16'($urandom), 16'($urandom));
            end else if (mode < 25) begin
                queue_req(OP_POSE, 4'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom));
            end else begin
                // poses around a waypoint, so arrival and index advance get exercised
                span = (mode < 65) ? int'(arr_rad) + 4 : 2048;
                if (span > 20000) span = 20000;
                queue_req(OP_POSE, 4'($urandom), near(gen_wp[s][0], span),
                          near(gen_wp[s][1], span), near(gen_wp[s][2], span));
            end
        end
    endtask

    initial begin
        logic [14:0] settings [6][3];
        settings = '{'{15'd0, 15'd0, 15'd0}, '{15'd1, 15'd32767, 15'd0},
                     '{15'd16, 15'd512, 15'd300}, '{15'd31, 15'd100, 15'd32767},
                     '{15'd3, 15'd2000, 15'd1000}, '{15'd17, 15'd32767, 15'd32767}};
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // fill every slot first so no pose ever reads an empty entry
        queue_req(OP_WRITE, 4'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        queue_req(OP_WRITE, 4'd1, 16'sh8000, 16'sh8000, 16'sh8000);
        queue_req(OP_WRITE, 4'd2, 16'sd0, 16'sd0, 16'sd0);
        queue_req(OP_WRITE, 4'd3, -16'sd300, 16'sd200, 16'sd5);
        queue_req(OP_WRITE, 4'd4, -16'sd300, -16'sd200, -16'sd5);
        for (int k = 5; k < 16; k++)
            queue_req(OP_WRITE, 4'(k), 16'($urandom), 16'($urandom), 16'($urandom));
        queue_req(OP_POSE, 4'd0, 16'sh8000, 16'sh8000, 16'sh8000);  // far, step limited
        queue_req(OP_POSE, 4'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff);  // zero offset
        queue_req(OP_POSE, 4'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        queue_req(OP_POSE, 4'd9, 16'sd10, 16'sd0, 16'sd0);           // negative x and y offset
        queue_req(OP_POSE, 4'd0, -16'sd250, 16'sd150, 16'sd0);
        queue_req(OP_POSE, 4'd0, -16'sd250, -16'sd150, 16'sd0);
        wait_idle();

        for (int ph = 0; ph < 10; ph++) begin
            if (ph < 6) begin
                write_reg(CFG_COUNT, settings[ph][0]);
                write_reg(CFG_STEP, settings[ph][1]);
                write_reg(CFG_RADIUS, settings[ph][2]);
            end else begin
                write_reg(CFG_COUNT, 15'($urandom_range(1, 16)));
                write_reg(CFG_STEP, 15'($urandom_range(0, 4000)));
                write_reg(CFG_RADIUS, 15'($urandom_range(0, 3000)));
            end
            no_idle = (ph % 4 == 2);
            random_batch(110);
            wait_idle();
        end

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
